// ----- rtl/scc_pkg.sv -----
// Shared widths and coordinate types for the segment/circle clipper.
// Depends on nothing; the interfaces and the clipper import it.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int COORD_BITS     = 16;
  localparam int ROOT_FRAC_BITS = 8;

  localparam int CW    = COORD_BITS;
  localparam int FRAC  = ROOT_FRAC_BITS;
  localparam int DLW   = CW + 1;              // deltas, circle center
  localparam int AW    = CW + 2;              // endpoint minus center
  localparam int AQW   = 2 * CW + 2;          // a = dx^2 + dy^2
  localparam int HW    = 2 * CW + 4;          // h
  localparam int CCW   = 2 * CW + 5;          // c
  localparam int HL    = HW / 2;
  localparam int AL    = AQW / 2;
  localparam int DW    = 4 * CW + 8;          // discriminant
  localparam int RADW  = 4 * CW + 6;          // radicand bits taken from D
  localparam int ROOTW = RADW / 2 + FRAC;     // root bits incl. fraction
  localparam int RW    = ROOTW + 2;           // root remainder
  localparam int QW    = AQW + FRAC;          // Q = a << FRAC
  localparam int NW    = HW + FRAC + 2;       // N1, N2
  localparam int QTW   = CW + 1;              // quotient magnitude
  localparam int MAGW  = QW + QTW;            // dividend magnitude
  localparam int NUMW  = DLW + NW + 1;        // dividend
  localparam int PLW   = HW + HL + 1;
  localparam int PCW   = CCW + (AQW - AL) + 1;
  localparam int PAW   = CW + AQW + 1;

  localparam int SQ_PER = 2;
  localparam int SQ_ST  = (ROOTW + SQ_PER - 1) / SQ_PER;
  localparam int DV_PER = 2;
  localparam int DV_ST  = (QTW + DV_PER - 1) / DV_PER;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic        [CW-1:0] ucoord_t;

endpackage

// ----- rtl/scc_req_if.sv -----
// Request channel of the clipper: circle box and segment endpoints.
// Depends on scc_pkg.
`timescale 1ns / 1ps

interface scc_req_if;
  import scc_pkg::*;

  logic    valid;
  logic    ready;
  coord_t  box_left;
  coord_t  box_top;
  ucoord_t box_width;
  coord_t  start_x;
  coord_t  start_y;
  coord_t  end_x;
  coord_t  end_y;

  modport source (output valid, box_left, box_top, box_width, start_x, start_y,
                  end_x, end_y, input ready);
  modport sink (input valid, box_left, box_top, box_width, start_x, start_y,
                end_x, end_y, output ready);
endinterface

// ----- rtl/scc_res_if.sv -----
// Result channel of the clipper: found flag and clipped endpoints.
// Depends on scc_pkg.
`timescale 1ns / 1ps

interface scc_res_if;
  import scc_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  coord_t clip_x1;
  coord_t clip_y1;
  coord_t clip_x2;
  coord_t clip_y2;

  modport source (output valid, found, clip_x1, clip_y1, clip_x2, clip_y2,
                  input ready);
  modport sink (input valid, found, clip_x1, clip_y1, clip_x2, clip_y2,
                output ready);
endinterface

// ----- rtl/segment_circle_clip.sv -----
// Segment/circle clipper: fully pipelined, one request per cycle while the
// result is not held. At default widths the square root has 22 stages, two
// root bits each, and the four parallel dividers have 9 stages, two quotient
// bits each. The whole pipe stalls together when the result is held.
// Depends on scc_pkg, scc_req_if, scc_res_if.
`timescale 1ns / 1ps

module segment_circle_clip (
  input logic       clk,
  input logic       rst,
  scc_req_if.sink   req,
  scc_res_if.source res
);
  import scc_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0]  x1;
    logic signed [CW-1:0]  y1;
    logic signed [CW-1:0]  x2;
    logic signed [CW-1:0]  y2;
    logic signed [DLW-1:0] dx;
    logic signed [DLW-1:0] dy;
  } pay_t;

  typedef struct packed {
    logic                  v;
    logic                  dpos;
    pay_t                  p;
    logic signed [HW-1:0]  h;
    logic [AQW-1:0]        a;
    logic [2*ROOTW-1:0]    rad;
    logic [RW-1:0]         rem;
    logic [ROOTW-1:0]      root;
  } sq_t;

  typedef struct packed {
    logic                  v;
    logic                  found;
    logic                  sel1;
    logic                  sel2;
    pay_t                  p;
    logic [QW-1:0]         q;
    logic [3:0]            neg;
    logic [3:0][QW-1:0]    rem;
    logic [3:0][QTW-1:0]   lo;
    logic [3:0][QTW-1:0]   quo;
  } dv_t;

  typedef struct packed {
    logic   found;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } out_t;

  function automatic sq_t sq_step(sq_t s);
    logic [RW-1:0] rs;
    logic [RW-1:0] t;
    rs = {s.rem[RW-3:0], s.rad[2*ROOTW-1 -: 2]};
    t = {s.root, 2'b01};
    s.rad = {s.rad[2*ROOTW-3:0], 2'b00};
    if (rs >= t) begin
      s.rem = rs - t;
      s.root = {s.root[ROOTW-2:0], 1'b1};
    end else begin
      s.rem = rs;
      s.root = {s.root[ROOTW-2:0], 1'b0};
    end
    return s;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    logic [QW:0] rs;
    for (int k = 0; k < 4; k++) begin
      rs = {s.rem[k], s.lo[k][QTW-1]};
      s.lo[k] = {s.lo[k][QTW-2:0], 1'b0};
      if (rs >= {1'b0, s.q}) begin
        s.rem[k] = QW'(rs - {1'b0, s.q});
        s.quo[k] = {s.quo[k][QTW-2:0], 1'b1};
      end else begin
        s.rem[k] = rs[QW-1:0];
        s.quo[k] = {s.quo[k][QTW-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  logic adv;
  logic res_v;
  out_t res_q;

  assign adv = !res_v || res.ready;
  assign req.ready = adv;

  // stage 1: deltas and offsets from center
  logic                  v1;
  pay_t                  p1;
  logic signed [AW-1:0]  ax1, by1;
  logic [CW-2:0]         r1;
  logic signed [DLW-1:0] cen_x, cen_y;

  always_comb begin
    cen_x = $signed({req.box_left[CW-1], req.box_left}) +
            $signed({2'b00, req.box_width[CW-1:1]});
    cen_y = $signed({req.box_top[CW-1], req.box_top}) +
            $signed({2'b00, req.box_width[CW-1:1]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
      p1.x1 <= req.start_x;
      p1.y1 <= req.start_y;
      p1.x2 <= req.end_x;
      p1.y2 <= req.end_y;
      p1.dx <= DLW'(req.end_x) - DLW'(req.start_x);
      p1.dy <= DLW'(req.end_y) - DLW'(req.start_y);
      ax1 <= AW'(req.start_x) - AW'(cen_x);
      by1 <= AW'(req.start_y) - AW'(cen_y);
      r1 <= req.box_width[CW-1:1];
    end
  end

  // stage 2: squares and cross products
  logic                  v2;
  pay_t                  p2;
  logic signed [AQW-1:0] pxx2, pyy2;
  logic signed [HW-1:0]  pxa2, pyb2;
  logic signed [CCW-1:0] paa2, pbb2, prr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      p2 <= p1;
      pxx2 <= AQW'(p1.dx) * AQW'(p1.dx);
      pyy2 <= AQW'(p1.dy) * AQW'(p1.dy);
      pxa2 <= HW'(p1.dx) * HW'(ax1);
      pyb2 <= HW'(p1.dy) * HW'(by1);
      paa2 <= CCW'(ax1) * CCW'(ax1);
      pbb2 <= CCW'(by1) * CCW'(by1);
      prr2 <= CCW'($signed({1'b0, r1})) * CCW'($signed({1'b0, r1}));
    end
  end

  // stage 3: quadratic coefficients
  logic                  v3;
  pay_t                  p3;
  logic [AQW-1:0]        a3;
  logic signed [HW-1:0]  h3;
  logic signed [CCW-1:0] c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
      p3 <= p2;
      a3 <= AQW'(pxx2 + pyy2);
      h3 <= pxa2 + pyb2;
      c3 <= paa2 + pbb2 - prr2;
    end
  end

  // stage 4: split products for h*h and a*c
  logic                  v4;
  pay_t                  p4;
  logic [AQW-1:0]        a4;
  logic signed [HW-1:0]  h4;
  logic signed [PLW-1:0] phl4, phh4;
  logic signed [PCW-1:0] pcl4, pch4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
      p4 <= p3;
      a4 <= a3;
      h4 <= h3;
      phl4 <= PLW'(h3) * PLW'($signed({1'b0, h3[HL-1:0]}));
      phh4 <= PLW'(h3) * PLW'($signed(h3[HW-1:HL]));
      pcl4 <= PCW'(c3) * PCW'($signed({1'b0, a3[AL-1:0]}));
      pch4 <= PCW'(c3) * PCW'($signed({1'b0, a3[AQW-1:AL]}));
    end
  end

  // stage 5: discriminant, feeds the root pipe
  sq_t                  sq [SQ_ST+1];
  logic signed [DW-1:0] d5;

  assign d5 = (DW'(phh4) <<< HL) + DW'(phl4) - (DW'(pch4) <<< AL) - DW'(pcl4);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].v <= 1'b0;
    end else if (adv) begin
      sq[0].v <= v4;
      sq[0].dpos <= !d5[DW-1] && (|d5);
      sq[0].p <= p4;
      sq[0].h <= h4;
      sq[0].a <= a4;
      sq[0].rad <= {d5[RADW-1:0], {(2*FRAC){1'b0}}};
      sq[0].rem <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar s = 0; s < SQ_ST; s++) begin : g_sq
    sq_t sq_next;
    always_comb begin
      sq_next = sq[s];
      for (int j = 0; j < SQ_PER; j++) begin
        if (s * SQ_PER + j < ROOTW) sq_next = sq_step(sq_next);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sq[s+1].v <= 1'b0;
      else if (adv) sq[s+1] <= sq_next;
    end
  end

  // stage 6: roots as numerators over Q, range checks
  logic                 v6, found6, sel16, sel26;
  pay_t                 p6;
  logic [AQW-1:0]       a6;
  logic [QW-1:0]        q6;
  logic signed [NW-1:0] n16, n26;
  logic signed [NW-1:0] hs, sx, qs, n1c, n2c;

  always_comb begin
    hs = NW'(sq[SQ_ST].h) <<< FRAC;
    sx = $signed({{(NW-ROOTW){1'b0}}, sq[SQ_ST].root});
    qs = $signed({{(NW-QW){1'b0}}, sq[SQ_ST].a, {FRAC{1'b0}}});
    n1c = -hs - sx;
    n2c = sx - hs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= sq[SQ_ST].v;
      found6 <= sq[SQ_ST].dpos && !(n1c >= qs) && !(n2c <= 0);
      sel16 <= n1c <= 0;
      sel26 <= n2c >= qs;
      p6 <= sq[SQ_ST].p;
      a6 <= sq[SQ_ST].a;
      q6 <= {sq[SQ_ST].a, {FRAC{1'b0}}};
      n16 <= n1c;
      n26 <= n2c;
    end
  end

  // stage 7: dividend products
  logic                   v7, found7, sel17, sel27;
  pay_t                   p7;
  logic [QW-1:0]          q7;
  logic signed [PAW-1:0]  pxa7, pya7;
  logic signed [NUMW-1:0] pdn7 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
      found7 <= found6;
      sel17 <= sel16;
      sel27 <= sel26;
      p7 <= p6;
      q7 <= q6;
      pxa7 <= PAW'(p6.x1) * PAW'($signed({1'b0, a6}));
      pya7 <= PAW'(p6.y1) * PAW'($signed({1'b0, a6}));
      pdn7[0] <= NUMW'(p6.dx) * NUMW'(n16);
      pdn7[1] <= NUMW'(p6.dy) * NUMW'(n16);
      pdn7[2] <= NUMW'(p6.dx) * NUMW'(n26);
      pdn7[3] <= NUMW'(p6.dy) * NUMW'(n26);
    end
  end

  // stage 8: signed dividends to magnitudes, feeds the divide pipe
  dv_t                    dv [DV_ST+1];
  logic signed [NUMW-1:0] num [4];
  logic [NUMW-1:0]        mag [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num[k] = (NUMW'(k[0] ? pya7 : pxa7) <<< FRAC) + pdn7[k];
      mag[k] = num[k][NUMW-1] ? NUMW'(-num[k]) : NUMW'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (adv) begin
      dv[0].v <= v7;
      dv[0].found <= found7;
      dv[0].sel1 <= sel17;
      dv[0].sel2 <= sel27;
      dv[0].p <= p7;
      dv[0].q <= q7;
      for (int k = 0; k < 4; k++) begin
        dv[0].neg[k] <= num[k][NUMW-1];
        dv[0].rem[k] <= mag[k][MAGW-1:QTW];
        dv[0].lo[k] <= mag[k][QTW-1:0];
        dv[0].quo[k] <= '0;
      end
    end
  end

  for (genvar s = 0; s < DV_ST; s++) begin : g_dv
    dv_t dv_next;
    always_comb begin
      dv_next = dv[s];
      for (int j = 0; j < DV_PER; j++) begin
        if (s * DV_PER + j < QTW) dv_next = dv_step(dv_next);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[s+1].v <= 1'b0;
      else if (adv) dv[s+1] <= dv_next;
    end
  end

  // result register: pick endpoint or crossing, zero when nothing found
  logic [QTW-1:0] qv [4];
  out_t           res_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qv[k] = dv[DV_ST].neg[k] ? QTW'(-dv[DV_ST].quo[k]) : dv[DV_ST].quo[k];
    end
    res_next = '0;
    if (dv[DV_ST].found) begin
      res_next.found = 1'b1;
      res_next.x1 = dv[DV_ST].sel1 ? dv[DV_ST].p.x1 : $signed(qv[0][CW-1:0]);
      res_next.y1 = dv[DV_ST].sel1 ? dv[DV_ST].p.y1 : $signed(qv[1][CW-1:0]);
      res_next.x2 = dv[DV_ST].sel2 ? dv[DV_ST].p.x2 : $signed(qv[2][CW-1:0]);
      res_next.y2 = dv[DV_ST].sel2 ? dv[DV_ST].p.y2 : $signed(qv[3][CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (adv) begin
      res_v <= dv[DV_ST].v;
      res_q <= res_next;
    end
  end

  assign res.valid   = res_v;
  assign res.found   = res_q.found;
  assign res.clip_x1 = res_q.x1;
  assign res.clip_y1 = res_q.y1;
  assign res.clip_x2 = res_q.x2;
  assign res.clip_y2 = res_q.y2;

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_v && !res_q.found |-> res_q.x1 == 0 && res_q.y1 == 0 &&
                              res_q.x2 == 0 && res_q.y2 == 0)
    else $error("miss result carries nonzero ends");

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !res_v)
    else $error("result valid right after reset");

  a_stall_root: assert property (@(posedge clk) disable iff (rst)
    !adv |=> sq[SQ_ST].v == $past(sq[SQ_ST].v) && dv[DV_ST].v == $past(dv[DV_ST].v))
    else $error("pipe moved during stall");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res_v && !res.ready |=> res_v && $stable(res_q))
    else $error("held result changed");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for segment_circle_clip: random and directed clip requests,
// predicted with exact wide integer arithmetic, compared result by result.
// Depends on scc_pkg, scc_req_if, scc_res_if and the clipper.
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;

  typedef struct packed {
    coord_t  box_left;
    coord_t  box_top;
    ucoord_t box_width;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } clip_req_t;

  typedef struct packed {
    logic   found;
    coord_t clip_x1;
    coord_t clip_y1;
    coord_t clip_x2;
    coord_t clip_y2;
  } clip_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1430;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scc_req_if req ();
  scc_res_if res ();

  segment_circle_clip dut (.clk(clk), .rst(rst), .req(req.sink), .res(res.source));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  clip_req_t pending_reqs[$];
  clip_res_t expected_clips[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        feeding_done = 1'b0;
  bit        drain_hold = 1'b0;
  int        hold_cycles = 0;
  bit        long_hold_req = 1'b0;
  int        send_gap = 0;

  function automatic logic signed [127:0] isqrt_frac(logic [127:0] d);
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [1:0]   pair;
    root = '0;
    rem = '0;
    for (int i = 0; i < 64 + FRAC; i++) begin
      pair = (i < 64) ? d[2*(63-i) +: 2] : 2'b00;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 1;
      end
    end
    return root;
  endfunction

  function automatic coord_t lerp_trunc(longint p0, longint d,
                                        logic signed [127:0] n,
                                        logic signed [127:0] q);
    logic signed [127:0] num;
    logic signed [127:0] quo;
    num = 128'(p0) * q + 128'(d) * n;
    quo = num / q;
    return coord_t'(quo[CW-1:0]);
  endfunction

  function automatic clip_res_t predict_clip(clip_req_t r);
    clip_res_t o;
    longint cx, cy, rad, x1, y1, x2, y2, dx, dy, ox, oy, a, h, c;
    logic signed [127:0] disc, s, hh, q, n1, n2;
    cx = longint'(r.box_left);
    cy = longint'(r.box_top);
    rad = longint'(r.box_width >> 1);
    x1 = longint'(r.start_x);
    y1 = longint'(r.start_y);
    x2 = longint'(r.end_x);
    y2 = longint'(r.end_y);
    dx = x2 - x1;
    dy = y2 - y1;
    ox = x1 - (cx + rad);
    oy = y1 - (cy + rad);
    a = dx * dx + dy * dy;
    h = dx * ox + dy * oy;
    c = ox * ox + oy * oy - rad * rad;
    disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
    o = '0;
    if (disc <= 0) return o;
    s = isqrt_frac(disc);
    hh = 128'(h) <<< FRAC;
    q = 128'(a) <<< FRAC;
    n1 = -hh - s;
    n2 = -hh + s;
    if (n1 >= q || n2 <= 0) return o;
    o.found = 1'b1;
    if (n1 <= 0) begin
      o.clip_x1 = r.start_x;
      o.clip_y1 = r.start_y;
    end else begin
      o.clip_x1 = lerp_trunc(x1, dx, n1, q);
      o.clip_y1 = lerp_trunc(y1, dy, n1, q);
    end
    if (n2 >= q) begin
      o.clip_x2 = r.end_x;
      o.clip_y2 = r.end_y;
    end else begin
      o.clip_x2 = lerp_trunc(x1, dx, n2, q);
      o.clip_y2 = lerp_trunc(y1, dy, n2, q);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic int rand_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 400)) - 200);
      2: return $urandom_range(0, 1) ? coord_t'(16'sh7fff - $urandom_range(0, 50))
                                     : coord_t'(16'sh8000 + $urandom_range(0, 50));
      default: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic clip_req_t make_req(int bl, int bt, int bw, int sx, int sy,
                                         int ex, int ey);
    clip_req_t r;
    r.box_left = coord_t'(bl);
    r.box_top = coord_t'(bt);
    r.box_width = ucoord_t'(bw);
    r.start_x = coord_t'(sx);
    r.start_y = coord_t'(sy);
    r.end_x = coord_t'(ex);
    r.end_y = coord_t'(ey);
    return r;
  endfunction

  // Mostly segments near a random circle so many of them cross it.
  function automatic clip_req_t rand_req();
    clip_req_t r;
    int cxc, cyc, rr, w;
    if ($urandom_range(0, 9) < 2) begin
      r = clip_req_t'({$urandom, $urandom, $urandom, $urandom});
      return r;
    end
    w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
    rr = w / 2;
    cxc = $urandom_range(0, 2000) - 1000;
    cyc = $urandom_range(0, 2000) - 1000;
    r = make_req(cxc - rr, cyc - rr, w,
                 cxc + $urandom_range(0, 3 * rr + 20) - (3 * rr + 20) / 2,
                 cyc + $urandom_range(0, 3 * rr + 20) - (3 * rr + 20) / 2,
                 cxc + $urandom_range(0, 3 * rr + 20) - (3 * rr + 20) / 2,
                 cyc + $urandom_range(0, 3 * rr + 20) - (3 * rr + 20) / 2);
    if ($urandom_range(0, 9) == 0) r.box_left = rand_coord();
    if ($urandom_range(0, 9) == 0) r.start_y = rand_coord();
    return r;
  endfunction

  initial begin
    pending_reqs.push_back(make_req(-100, -100, 200, -200, 0, 200, 0));
    pending_reqs.push_back(make_req(-100, -100, 200, -10, 5, 10, -5));
    pending_reqs.push_back(make_req(-100, -100, 200, -10, 5, 300, 40));
    pending_reqs.push_back(make_req(-100, -100, 200, 300, 300, 400, 300));
    pending_reqs.push_back(make_req(-100, -100, 200, 5, 5, 5, 5));
    pending_reqs.push_back(make_req(-100, -100, 200, 50, 50, 50, 50));
    pending_reqs.push_back(make_req(-100, -100, 200, 200, 0, 300, 0));
    pending_reqs.push_back(make_req(-100, -100, 200, -200, 100, 200, 100));
    pending_reqs.push_back(make_req(0, 0, 0, -5, 0, 5, 0));
    pending_reqs.push_back(make_req(0, 0, 1, -5, 0, 5, 0));
    pending_reqs.push_back(make_req(0, 0, 3, -5, 1, 5, 1));
    pending_reqs.push_back(make_req(-32768, -32768, 65535, -32768, -32768,
                                    32767, 32767));
    pending_reqs.push_back(make_req(32767, 32767, 65535, -32768, 32767,
                                    32767, -32768));
    pending_reqs.push_back(make_req(-32768, 32767, 65534, 32767, -32768,
                                    -32768, 32767));
    pending_reqs.push_back(make_req(-32768, -32768, 65535, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32767, -32768, 0, 32767, -32768, -32768, 32767));
    pending_reqs.push_back(make_req(-1, -1, 65535, -1, -1, 1, 1));
    pending_reqs.push_back(make_req(-300, -300, 600, 400, 300, -400, -300));
    for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(rand_req());
    feeding_done = 1'b1;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: one request per accept, random gaps, one pause to full drain.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.box_left <= '0;
      req.box_top <= '0;
      req.box_width <= '0;
      req.start_x <= '0;
      req.start_y <= '0;
      req.end_x <= '0;
      req.end_y <= '0;
      send_gap <= 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid && req.ready) begin
        expected_clips.push_back(predict_clip(clip_req_t'({req.box_left, req.box_top,
          req.box_width, req.start_x, req.start_y, req.end_x, req.end_y})));
        if (pending_reqs.size() == 1000) drain_hold <= 1'b1;
      end
      if (drain_hold && expected_clips.size() == 0 && !(req.valid && req.ready))
        drain_hold <= 1'b0;
      if (send_gap > 0 || drain_hold || (req.valid && req.ready &&
                                         pending_reqs.size() == 1000)) begin
        req.valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        clip_req_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        {req.box_left, req.box_top, req.box_width, req.start_x, req.start_y,
         req.end_x, req.end_y} <= r;
        send_gap <= (pending_reqs.size() > 600 && pending_reqs.size() < 900)
                    ? 0 : rand_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while requests stream in.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_cycles <= 0;
      long_hold_req <= 1'b0;
    end else begin
      if (!long_hold_req && pending_reqs.size() == 800) begin
        long_hold_req <= 1'b1;
        hold_cycles <= 200;
        res.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 8) begin
        hold_cycles <= rand_gap();
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (expected_clips.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        clip_res_t e;
        e = expected_clips.pop_front();
        if (res.found !== e.found) report_mismatch("found", res.found, e.found);
        if (res.clip_x1 !== e.clip_x1) report_mismatch("clip_x1", res.clip_x1, e.clip_x1);
        if (res.clip_y1 !== e.clip_y1) report_mismatch("clip_y1", res.clip_y1, e.clip_y1);
        if (res.clip_x2 !== e.clip_x2) report_mismatch("clip_x2", res.clip_x2, e.clip_x2);
        if (res.clip_y2 !== e.clip_y2) report_mismatch("clip_y2", res.clip_y2, e.clip_y2);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    wait (!rst);
    wait (feeding_done && pending_reqs.size() == 0);
    @(posedge clk);
    wait (!req.valid && expected_clips.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_clips.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- segment_circle_clip.f -----
rtl/scc_pkg.sv
rtl/scc_req_if.sv
rtl/scc_res_if.sv
rtl/segment_circle_clip.sv
tb/sv/tb_top.sv
